@@ src/bpcm_pkg.sv @@
package bpcm_pkg;

    localparam int CMD_W        = 2;
    localparam int BYTE_W       = 8;
    localparam int HOP_W        = 13;
    localparam int SLOT_W       = 4;
    localparam int ELEM_W       = 7;
    localparam int STRIDE_W     = 11;

    localparam int POWER_W      = 28;
    localparam int CLIP_W       = 22;
    localparam int EPOWER_W     = 25;
    localparam int ECLIP_W      = 19;
    localparam int HOPS_W       = 14;
    localparam int PASS_W       = 32;

    localparam int DEF_SLOTS    = 16;
    localparam int DEF_ELEMENTS = 128;
    localparam int DEF_MAX_HOPS = 8192;

    // index fields cap how many entries can ever be addressed
    localparam int HOP_SPAN     = 1 << HOP_W;
    localparam int SLOT_SPAN    = 1 << SLOT_W;
    localparam int ELEM_SPAN    = 1 << ELEM_W;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCUM     = 2'd0,
        CMD_CLEAR     = 2'd1,
        CMD_READ_SLOT = 2'd2,
        CMD_READ_ELEM = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [BYTE_W-1:0] sample_byte;
        logic [HOP_W-1:0]  hop_index;
        logic [SLOT_W-1:0] slot_index;
        logic [ELEM_W-1:0] element_index;
    } req_word_t;

    typedef struct packed {
        logic [POWER_W-1:0] power_sum;
        logic [CLIP_W-1:0]  clip_low_count;
        logic [CLIP_W-1:0]  clip_high_count;
        logic [ECLIP_W-1:0] clip_both_count;
        logic [HOPS_W-1:0]  hops_counted;
        logic [PASS_W-1:0]  passes_done;
        logic               sample_taken;
    } rsp_word_t;

    // control from the top level to the accumulator tables
    typedef struct packed {
        logic rd;         // word accepted, issue table reads
        logic commit;     // word in flight completes this cycle
        logic take;       // accumulate into the tables
        logic clear;      // empty the tables
        logic read_slot;  // in-range slot readback
        logic read_elem;  // in-range element readback
    } tbl_ctrl_t;

    typedef struct packed {
        logic [POWER_W-1:0] power;
        logic [CLIP_W-1:0]  clip_low;
        logic [CLIP_W-1:0]  clip_high;
        logic [ECLIP_W-1:0] clip_both;
    } tbl_read_t;

endpackage

@@ src/bpcm_ram.sv @@
module bpcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/bpcm_stride_map.sv @@
module bpcm_stride_map
    import bpcm_pkg::*;
#(
    parameter int MAX_HOPS = DEF_MAX_HOPS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [STRIDE_W-1:0] stride,
    input  logic                restart,
    input  logic                rd,
    input  logic [HOP_W-1:0]    rd_hop,
    output logic                ready,
    output logic                hit
);

    localparam int HOP_DEPTH = (MAX_HOPS < HOP_SPAN) ? MAX_HOPS : HOP_SPAN;
    localparam int HOP_AW    = (HOP_DEPTH > 1) ? $clog2(HOP_DEPTH) : 1;

    logic                sweeping_reg;
    logic [HOP_AW-1:0]   cnt_reg;
    logic [HOP_AW-1:0]   cnt_next;
    logic [STRIDE_W-1:0] rem_reg;
    logic [STRIDE_W-1:0] rem_next;
    logic [STRIDE_W:0]   rem_inc;
    logic [STRIDE_W-1:0] eff_stride;
    logic                last;
    logic                map_bit;

    // stride zero behaves as one
    assign eff_stride = (stride == '0) ? STRIDE_W'(1) : stride;
    assign rem_inc    = {1'b0, rem_reg} + 1'b1;
    assign rem_next   = (rem_inc == {1'b0, eff_stride}) ? '0 : rem_inc[STRIDE_W-1:0];
    assign last       = (cnt_reg == HOP_AW'(HOP_DEPTH - 1));
    assign cnt_next   = cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweeping_reg <= 1'b1;
            cnt_reg      <= '0;
            rem_reg      <= '0;
        end
        else if (restart)
        begin
            sweeping_reg <= 1'b1;
            cnt_reg      <= '0;
            rem_reg      <= '0;
        end
        else if (sweeping_reg)
        begin
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            if (last)
            begin
                sweeping_reg <= 1'b0;
            end
        end
    end

    // one bit per hop: set where hop is a multiple of the stride
    bpcm_ram #(
        .WIDTH (1),
        .DEPTH (HOP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (sweeping_reg),
        .waddr (cnt_reg),
        .wdata (rem_reg == '0),
        .re    (rd),
        .raddr (rd_hop[HOP_AW-1:0]),
        .rdata (map_bit)
    );

    assign ready = !sweeping_reg;
    assign hit   = map_bit;

    assert property (@(posedge clk) disable iff (!rst_n) restart |=> sweeping_reg)
        else $error("stride map did not restart its sweep");

endmodule

@@ src/bpcm_tables.sv @@
module bpcm_tables
    import bpcm_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int ELEMENTS = DEF_ELEMENTS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tbl_ctrl_t         ctrl,
    input  logic [SLOT_W-1:0] rd_slot,
    input  logic [ELEM_W-1:0] rd_elem,
    input  req_word_t         item,
    output tbl_read_t         rd_out
);

    localparam int SLOT_DEPTH = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;
    localparam int ELEM_DEPTH = (ELEMENTS < ELEM_SPAN) ? ELEMENTS : ELEM_SPAN;
    localparam int SLOT_AW    = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int ELEM_AW    = (ELEM_DEPTH > 1) ? $clog2(ELEM_DEPTH) : 1;
    localparam int SWORD_W    = POWER_W + 2 * CLIP_W;
    localparam int EWORD_W    = EPOWER_W + ECLIP_W;

    logic [SLOT_AW-1:0]    slot_a;
    logic [ELEM_AW-1:0]    elem_a;
    logic [SLOT_DEPTH-1:0] slot_vld_reg;
    logic [ELEM_DEPTH-1:0] elem_vld_reg;

    logic                  slot_we;
    logic                  elem_we;
    logic [SWORD_W-1:0]    slot_rdata;
    logic [EWORD_W-1:0]    elem_rdata;
    logic [SWORD_W-1:0]    slot_wdata;
    logic [EWORD_W-1:0]    elem_wdata;

    logic                  fwd_slot_hit_reg;
    logic                  fwd_elem_hit_reg;
    logic [SWORD_W-1:0]    fwd_slot_data_reg;
    logic [EWORD_W-1:0]    fwd_elem_data_reg;

    logic [SWORD_W-1:0]    slot_cur;
    logic [EWORD_W-1:0]    elem_cur;
    logic [POWER_W-1:0]    s_pow;
    logic [CLIP_W-1:0]     s_lo;
    logic [CLIP_W-1:0]     s_hi;
    logic [EPOWER_W-1:0]   e_pow;
    logic [ECLIP_W-1:0]    e_clip;

    logic signed [3:0]     re_s;
    logic signed [3:0]     im_s;
    logic signed [7:0]     re_sq;
    logic signed [7:0]     im_sq;
    logic [7:0]            pwr;
    logic [1:0]            n_lo;
    logic [1:0]            n_hi;
    logic [2:0]            n_both;

    logic [POWER_W:0]      s_pow_sum;
    logic [CLIP_W:0]       s_lo_sum;
    logic [CLIP_W:0]       s_hi_sum;
    logic [EPOWER_W:0]     e_pow_sum;
    logic [ECLIP_W:0]      e_clip_sum;

    assign slot_a = item.slot_index[SLOT_AW-1:0];
    assign elem_a = item.element_index[ELEM_AW-1:0];

    // offset-coded nibble: flipping the top bit gives two's complement
    assign re_s  = {~item.sample_byte[7], item.sample_byte[6:4]};
    assign im_s  = {~item.sample_byte[3], item.sample_byte[2:0]};
    assign re_sq = re_s * re_s;
    assign im_sq = im_s * im_s;
    assign pwr   = $unsigned(re_sq) + $unsigned(im_sq);
    assign n_lo  = {1'b0, item.sample_byte[7:4] == 4'h0}
                 + {1'b0, item.sample_byte[3:0] == 4'h0};
    assign n_hi  = {1'b0, item.sample_byte[7:4] == 4'hF}
                 + {1'b0, item.sample_byte[3:0] == 4'hF};
    assign n_both = {1'b0, n_lo} + {1'b0, n_hi};

    // entry as it stood after the edge that issued the read
    always_comb
    begin
        if (!slot_vld_reg[slot_a])
        begin
            slot_cur = '0;
        end
        else if (fwd_slot_hit_reg)
        begin
            slot_cur = fwd_slot_data_reg;
        end
        else
        begin
            slot_cur = slot_rdata;
        end

        if (!elem_vld_reg[elem_a])
        begin
            elem_cur = '0;
        end
        else if (fwd_elem_hit_reg)
        begin
            elem_cur = fwd_elem_data_reg;
        end
        else
        begin
            elem_cur = elem_rdata;
        end
    end

    assign {s_pow, s_lo, s_hi} = slot_cur;
    assign {e_pow, e_clip}     = elem_cur;

    // saturating adds: carry out means the sum passed the max
    assign s_pow_sum  = {1'b0, s_pow} + (POWER_W + 1)'(pwr);
    assign s_lo_sum   = {1'b0, s_lo} + (CLIP_W + 1)'(n_lo);
    assign s_hi_sum   = {1'b0, s_hi} + (CLIP_W + 1)'(n_hi);
    assign e_pow_sum  = {1'b0, e_pow} + (EPOWER_W + 1)'(pwr);
    assign e_clip_sum = {1'b0, e_clip} + (ECLIP_W + 1)'(n_both);

    assign slot_wdata = {
        s_pow_sum[POWER_W]  ? {POWER_W{1'b1}} : s_pow_sum[POWER_W-1:0],
        s_lo_sum[CLIP_W]    ? {CLIP_W{1'b1}}  : s_lo_sum[CLIP_W-1:0],
        s_hi_sum[CLIP_W]    ? {CLIP_W{1'b1}}  : s_hi_sum[CLIP_W-1:0]
    };
    assign elem_wdata = {
        e_pow_sum[EPOWER_W] ? {EPOWER_W{1'b1}} : e_pow_sum[EPOWER_W-1:0],
        e_clip_sum[ECLIP_W] ? {ECLIP_W{1'b1}}  : e_clip_sum[ECLIP_W-1:0]
    };

    assign slot_we = ctrl.commit && ctrl.take;
    assign elem_we = ctrl.commit && ctrl.take;

    bpcm_ram #(
        .WIDTH (SWORD_W),
        .DEPTH (SLOT_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_a),
        .wdata (slot_wdata),
        .re    (ctrl.rd),
        .raddr (rd_slot[SLOT_AW-1:0]),
        .rdata (slot_rdata)
    );

    bpcm_ram #(
        .WIDTH (EWORD_W),
        .DEPTH (ELEM_DEPTH)
    ) u_elem_ram (
        .clk   (clk),
        .we    (elem_we),
        .waddr (elem_a),
        .wdata (elem_wdata),
        .re    (ctrl.rd),
        .raddr (rd_elem[ELEM_AW-1:0]),
        .rdata (elem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_vld_reg     <= '0;
            elem_vld_reg     <= '0;
            fwd_slot_hit_reg <= 1'b0;
            fwd_elem_hit_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.commit && ctrl.clear)
            begin
                slot_vld_reg <= '0;
                elem_vld_reg <= '0;
            end
            else
            begin
                if (slot_we)
                begin
                    slot_vld_reg[slot_a] <= 1'b1;
                end
                if (elem_we)
                begin
                    elem_vld_reg[elem_a] <= 1'b1;
                end
            end
            // a write on the same edge as the read is not seen by the RAM
            if (ctrl.rd)
            begin
                fwd_slot_hit_reg <= slot_we && (slot_a == rd_slot[SLOT_AW-1:0]);
                fwd_elem_hit_reg <= elem_we && (elem_a == rd_elem[ELEM_AW-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
        begin
            fwd_slot_data_reg <= slot_wdata;
            fwd_elem_data_reg <= elem_wdata;
        end
    end

    always_comb
    begin
        rd_out = '0;
        if (ctrl.read_slot)
        begin
            rd_out.power     = s_pow;
            rd_out.clip_low  = s_lo;
            rd_out.clip_high = s_hi;
        end
        else if (ctrl.read_elem)
        begin
            rd_out.power     = POWER_W'(e_pow);
            rd_out.clip_both = e_clip;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit && ctrl.clear |=> slot_vld_reg == '0 && elem_vld_reg == '0)
        else $error("tables not emptied by clear");

endmodule

@@ src/band_power_clip_monitor.sv @@
// channel   direction  handshake                 word
// req       in         req_valid / req_stall     req_word_t: command, sample, hop, slot, element
// rsp       out        rsp_valid / rsp_stall     rsp_word_t: sums, clip counts, tallies
// cfg       in         cfg_valid / cfg_ready     hop stride, 11 bits
//
// One word per cycle sustained while the hop map is ready and rsp is not stalled: table
// reads issue at acceptance, and the update and write-back land when the word in flight
// commits, with a write forwarded when the next word hits it. rsp_valid rises at that commit.
// After reset and after every stride write the hop map is rebuilt, one hop per cycle;
// req_stall stays high meanwhile. A stalled rsp holds the word in flight and stalls req.
module band_power_clip_monitor
    import bpcm_pkg::*;
#(
    parameter int SLOTS    = DEF_SLOTS,
    parameter int ELEMENTS = DEF_ELEMENTS,
    parameter int MAX_HOPS = DEF_MAX_HOPS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_word_t           req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_word_t           rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STRIDE_W-1:0] cfg_data
);

    logic [STRIDE_W-1:0] hop_stride_reg;
    logic                cfg_we;

    logic                map_ready;
    logic                map_hit;

    logic                accept;
    logic                commit;
    logic                rsp_free;
    logic                busy_reg;
    req_word_t           item_reg;

    logic                slot_ok;
    logic                elem_ok;
    logic                hop_ok;
    logic                take;
    tbl_ctrl_t           ctrl;
    tbl_read_t           tbl_rd;

    logic [HOPS_W-1:0]   hop_tally_reg;
    logic [HOPS_W-1:0]   hop_tally_next;
    logic [PASS_W-1:0]   pass_tally_reg;
    logic [PASS_W-1:0]   pass_tally_next;
    logic [HOPS_W-1:0]   hops_out;

    logic                rsp_valid_reg;
    rsp_word_t           rsp_reg;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_stride_reg <= STRIDE_RESET;
        end
        else if (cfg_we)
        begin
            hop_stride_reg <= cfg_data;
        end
    end

    bpcm_stride_map #(
        .MAX_HOPS (MAX_HOPS)
    ) u_stride_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .stride  (hop_stride_reg),
        .restart (cfg_we),
        .rd      (accept),
        .rd_hop  (req.hop_index),
        .ready   (map_ready),
        .hit     (map_hit)
    );

    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign commit    = busy_reg && rsp_free;
    assign req_stall = !map_ready || (busy_reg && !rsp_free);
    assign accept    = req_valid && !req_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            busy_reg <= 1'b1;
        end
        else if (commit)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

    assign slot_ok = 32'(item_reg.slot_index) < SLOTS;
    assign elem_ok = 32'(item_reg.element_index) < ELEMENTS;
    assign hop_ok  = 32'(item_reg.hop_index) < MAX_HOPS;
    assign take    = (item_reg.command == CMD_ACCUM) && hop_ok && slot_ok && elem_ok
                   && map_hit;

    always_comb
    begin
        ctrl           = '0;
        ctrl.rd        = accept;
        ctrl.commit    = commit;
        ctrl.take      = take;
        ctrl.clear     = (item_reg.command == CMD_CLEAR);
        ctrl.read_slot = (item_reg.command == CMD_READ_SLOT) && slot_ok;
        ctrl.read_elem = (item_reg.command == CMD_READ_ELEM) && elem_ok;
    end

    bpcm_tables #(
        .SLOTS    (SLOTS),
        .ELEMENTS (ELEMENTS)
    ) u_tables (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_slot (req.slot_index),
        .rd_elem (req.element_index),
        .item    (item_reg),
        .rd_out  (tbl_rd)
    );

    // hop and pass tallies
    always_comb
    begin
        hop_tally_next  = hop_tally_reg;
        pass_tally_next = pass_tally_reg;
        hops_out        = hop_tally_reg;
        case (item_reg.command)
            CMD_ACCUM:
            begin
                // first sample of a hop is the one at slot 0, element 0
                if (take && item_reg.slot_index == '0 && item_reg.element_index == '0
                    && hop_tally_reg != {HOPS_W{1'b1}})
                begin
                    hop_tally_next = hop_tally_reg + 1'b1;
                end
                hops_out = hop_tally_next;
            end
            CMD_CLEAR:
            begin
                hop_tally_next = '0;
                if (hop_tally_reg != '0)
                begin
                    pass_tally_next = pass_tally_reg + 1'b1;
                end
            end
            default:
            begin
                hops_out = hop_tally_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hop_tally_reg  <= '0;
            pass_tally_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (commit)
            begin
                hop_tally_reg  <= hop_tally_next;
                pass_tally_reg <= pass_tally_next;
                rsp_valid_reg  <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            rsp_reg.power_sum       <= tbl_rd.power;
            rsp_reg.clip_low_count  <= tbl_rd.clip_low;
            rsp_reg.clip_high_count <= tbl_rd.clip_high;
            rsp_reg.clip_both_count <= tbl_rd.clip_both;
            rsp_reg.hops_counted    <= hops_out;
            rsp_reg.passes_done     <= pass_tally_next;
            rsp_reg.sample_taken    <= take;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> busy_reg)
        else $error("accepted word not in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(busy_reg))
        else $error("response without a word in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.sample_taken
            |-> rsp_reg.power_sum == '0 && rsp_reg.clip_both_count == '0)
        else $error("accumulate response carries table data");

    assert property (@(posedge clk) disable iff (!rst_n)
        pass_tally_reg == $past(pass_tally_reg)
            || pass_tally_reg == $past(pass_tally_reg) + 1'b1)
        else $error("pass tally jumped");

endmodule
